// File: rtl/core/skc_pkg.sv
// Shared constants, register indexes, op codes and state type of the scalar
// Kalman calibrator. No dependencies; every other file in rtl/core uses it.
package skc_pkg;

   localparam int DATA_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int CSR_IDX_W         = 3;
   localparam int PROD_W            = 2 * DATA_W;

   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_ERROR     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_EST_ERROR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_SLOPE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_OFFSET     = 3'd4;

   localparam logic [DATA_W-1:0] MEAS_ERROR_RESET     = 32'd65536;
   localparam logic [DATA_W-1:0] INIT_EST_ERROR_RESET = 32'd65536;
   localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET  = 32'd655;
   localparam logic [DATA_W-1:0] CAL_SLOPE_RESET      = 32'd65536;
   localparam logic [DATA_W-1:0] CAL_OFFSET_RESET     = 32'd0;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_SET    = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DIV   = 7'b0000010,
      S_STEP  = 7'b0000100,
      S_KEEP  = 7'b0001000,
      S_NOISE = 7'b0010000,
      S_CAL   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

endpackage

// File: rtl/core/skc_req_if.sv
// Request channel of the scalar Kalman calibrator: valid, ready, op, sample.
// Depends on skc_pkg for the data width.
interface skc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         op;
   logic [skc_pkg::DATA_W-1:0]   sample;

   modport source (output valid, output op, output sample, input ready);
   modport sink   (input valid, input op, input sample, output ready);
endinterface

// File: rtl/core/skc_rsp_if.sv
// Response channel of the scalar Kalman calibrator: valid, ready, filtered
// and calibrated values. Depends on skc_pkg for the data width.
interface skc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [skc_pkg::DATA_W-1:0]   filtered;
   logic [skc_pkg::DATA_W-1:0]   calibrated;

   modport source (output valid, output filtered, output calibrated, input ready);
   modport sink   (input valid, input filtered, input calibrated, output ready);
endinterface

// File: rtl/core/skc_divider.sv
// Restoring radix-2 divider producing the Kalman gain, one quotient bit per
// cycle, FRAC_BITS+1 quotient bits in all. Depends on skc_pkg.
module skc_divider #(
   parameter int FRAC_BITS = skc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [skc_pkg::DATA_W-1:0]     dividend,
   input  logic [skc_pkg::DATA_W:0]       divisor,
   output logic                           done,
   output logic [FRAC_BITS:0]             quotient
);

   localparam int REM_W = skc_pkg::DATA_W + 2;
   localparam int CNT_W = $clog2(FRAC_BITS + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [FRAC_BITS:0] quo_ff, quo_in;
   logic [skc_pkg::DATA_W:0] div_ff, div_in;

   logic [REM_W-1:0]  div_ext;
   logic              q_bit;
   logic [REM_W-1:0]  rem_sel;

   always_comb begin
      div_ext = {1'b0, div_ff};
      q_bit   = rem_ff >= div_ext;
      rem_sel = q_bit ? (rem_ff - div_ext) : rem_ff;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {2'b00, dividend};
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = {rem_sel[REM_W-2:0], 1'b0};
         quo_in = {quo_ff[FRAC_BITS-1:0], q_bit};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(FRAC_BITS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/core/skc_multiplier.sv
// Shared 32 x 32 unsigned multiplier with a registered product, used for
// every product of the filter and calibration. Depends on skc_pkg.
module skc_multiplier (
   input  logic                           clock,
   input  logic [skc_pkg::DATA_W-1:0]     op_a,
   input  logic [skc_pkg::DATA_W-1:0]     op_b,
   output logic [skc_pkg::PROD_W-1:0]     product
);

   logic [skc_pkg::PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      prod_in = skc_pkg::PROD_W'(op_a) * skc_pkg::PROD_W'(op_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// File: rtl/core/scalar_kalman_calibrator.sv
// Scalar Kalman calibrator top level: sequencer, state and config registers.
// Depends on skc_pkg, skc_req_if, skc_rsp_if, skc_divider, skc_multiplier.
//
// Usage: each req transaction carries op and a signed fixed-point sample;
// each one yields exactly one rsp transaction with the filtered value and
// the calibrated value (filtered * slope + offset, saturated).
// Configuration is written through csr_we / csr_index / csr_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. Writing init_est_error also reloads the error state.
// One transaction is worked at a time; req.ready is high only in idle.
// Filter op: the gain divider runs first, then the shared multiplier
// runs four products back to back before rsp.valid rises.
// Set op: no divide; S_CAL and S_DONE follow, then rsp.valid rises.
// The next req transaction can be taken in the cycle after the result is
// loaded into the output register, even while rsp.valid still waits.
// A stalled receiver holds the output register; a finished result then
// waits in the sequencer until the register frees up.
// Reset is synchronous: registers take their reset values, the estimate
// clears, the error state loads the init_est_error reset value.
module scalar_kalman_calibrator #(
   parameter int FRAC_BITS = skc_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   skc_req_if.sink                           req,
   skc_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [skc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [skc_pkg::DATA_W-1:0]        csr_wdata
);

   localparam int DW = skc_pkg::DATA_W;
   localparam int PW = skc_pkg::PROD_W;
   localparam logic [FRAC_BITS:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic signed [PW-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [PW-1:0] S32_MIN = -64'sh0000_0000_8000_0000;

   skc_pkg::state_type state_ff, state_in;

   logic [DW-1:0]      meas_ff, meas_in;
   logic [DW-1:0]      init_ff, init_in;
   logic [DW-1:0]      noise_q_ff, noise_q_in;
   logic [DW-1:0]      slope_ff, slope_in;
   logic [DW-1:0]      offset_ff, offset_in;

   logic [DW-1:0]      last_ff, last_in;
   logic [DW-1:0]      est_ff, est_in;

   logic               op_ff, op_in;
   logic [DW:0]        diff_ff, diff_in;
   logic [DW:0]        den_ff, den_in;
   logic [FRAC_BITS:0] gain_ff, gain_in;
   logic [DW-1:0]      change_ff, change_in;
   logic [DW-1:0]      keep_ff, keep_in;
   logic [DW-1:0]      filt_ff, filt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]      rsp_filt_ff, rsp_filt_in;
   logic [DW-1:0]      rsp_cal_ff, rsp_cal_in;

   logic               div_start;
   logic               div_done;
   logic [FRAC_BITS:0] div_quo;
   logic [DW:0]        den_now;

   logic [DW-1:0]      mul_a, mul_b;
   logic [PW-1:0]      product;
   logic [PW-1:0]      prod_shift;

   logic [DW:0]        diff_neg;
   logic [DW-1:0]      diff_mag;
   logic [DW:0]        step_s;
   logic [DW:0]        filt_new;
   logic [PW-1:0]      ne_sum;
   logic [DW-1:0]      filt_mag, slope_mag;
   logic               cal_neg;
   logic signed [PW-1:0] cal_signed, cal_sum;
   logic [DW-1:0]      cal_sat;
   logic               accept;

   skc_divider #(.FRAC_BITS(FRAC_BITS)) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (est_ff),
      .divisor  (den_now),
      .done     (div_done),
      .quotient (div_quo)
   );

   skc_multiplier u_multiplier (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   assign accept  = req.valid && req.ready;
   assign den_now = {1'b0, est_ff} + {1'b0, meas_ff};

   always_comb begin
      prod_shift = product >> FRAC_BITS;
      diff_neg   = (DW+1)'(0) - diff_ff;
      diff_mag   = diff_ff[DW] ? diff_neg[DW-1:0] : diff_ff[DW-1:0];
      step_s     = diff_ff[DW] ? ((DW+1)'(0) - {1'b0, prod_shift[DW-1:0]})
                               : {1'b0, prod_shift[DW-1:0]};
      filt_new   = {last_ff[DW-1], last_ff} + step_s;
      ne_sum     = PW'(keep_ff) + prod_shift;
      filt_mag   = filt_ff[DW-1] ? (DW'(0) - filt_ff) : filt_ff;
      slope_mag  = slope_ff[DW-1] ? (DW'(0) - slope_ff) : slope_ff;
      cal_neg    = filt_ff[DW-1] ^ slope_ff[DW-1];
      cal_signed = cal_neg ? -$signed(prod_shift) : $signed(prod_shift);
      cal_sum    = cal_signed + PW'($signed(offset_ff));
      if (cal_sum > S32_MAX) begin
         cal_sat = S32_MAX[DW-1:0];
      end else if (cal_sum < S32_MIN) begin
         cal_sat = S32_MIN[DW-1:0];
      end else begin
         cal_sat = cal_sum[DW-1:0];
      end
   end

   always_comb begin
      case (state_ff)
         skc_pkg::S_STEP: begin
            mul_a = DW'(gain_ff);
            mul_b = diff_mag;
         end
         skc_pkg::S_KEEP: begin
            mul_a = DW'(ONE_Q - gain_ff);
            mul_b = est_ff;
         end
         skc_pkg::S_NOISE: begin
            mul_a = change_ff;
            mul_b = noise_q_ff;
         end
         default: begin
            mul_a = filt_mag;
            mul_b = slope_mag;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      meas_in      = meas_ff;
      init_in      = init_ff;
      noise_q_in   = noise_q_ff;
      slope_in     = slope_ff;
      offset_in    = offset_ff;
      last_in      = last_ff;
      est_in       = est_ff;
      op_in        = op_ff;
      diff_in      = diff_ff;
      den_in       = den_ff;
      gain_in      = gain_ff;
      change_in    = change_ff;
      keep_in      = keep_ff;
      filt_in      = filt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_filt_in  = rsp_filt_ff;
      rsp_cal_in   = rsp_cal_ff;
      div_start    = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         skc_pkg::S_IDLE: begin
            if (accept) begin
               op_in   = req.op;
               diff_in = {req.sample[DW-1], req.sample} - {last_ff[DW-1], last_ff};
               den_in  = den_now;
               if (req.op == skc_pkg::OP_SET) begin
                  filt_in  = req.sample;
                  state_in = skc_pkg::S_CAL;
               end else begin
                  div_start = 1'b1;
                  state_in  = skc_pkg::S_DIV;
               end
            end
         end
         skc_pkg::S_DIV: begin
            if (div_done) begin
               gain_in  = (den_ff == '0) ? '0 : div_quo;
               state_in = skc_pkg::S_STEP;
            end
         end
         skc_pkg::S_STEP: begin
            state_in = skc_pkg::S_KEEP;
         end
         skc_pkg::S_KEEP: begin
            change_in = prod_shift[DW-1:0];
            filt_in   = filt_new[DW-1:0];
            state_in  = skc_pkg::S_NOISE;
         end
         skc_pkg::S_NOISE: begin
            keep_in  = prod_shift[DW-1:0];
            state_in = skc_pkg::S_CAL;
         end
         skc_pkg::S_CAL: begin
            if (op_ff == skc_pkg::OP_FILTER) begin
               est_in  = (|ne_sum[PW-1:DW]) ? '1 : ne_sum[DW-1:0];
               last_in = filt_ff;
            end
            state_in = skc_pkg::S_DONE;
         end
         skc_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_filt_in  = filt_ff;
               rsp_cal_in   = cal_sat;
               state_in     = skc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = skc_pkg::S_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            skc_pkg::CSR_MEAS_ERROR: meas_in = csr_wdata;
            skc_pkg::CSR_INIT_EST_ERROR: begin
               init_in = csr_wdata;
               est_in  = csr_wdata;
            end
            skc_pkg::CSR_PROCESS_NOISE: noise_q_in = csr_wdata;
            skc_pkg::CSR_CAL_SLOPE:     slope_in   = csr_wdata;
            skc_pkg::CSR_CAL_OFFSET:    offset_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skc_pkg::S_IDLE;
         meas_ff      <= skc_pkg::MEAS_ERROR_RESET;
         init_ff      <= skc_pkg::INIT_EST_ERROR_RESET;
         noise_q_ff   <= skc_pkg::PROCESS_NOISE_RESET;
         slope_ff     <= skc_pkg::CAL_SLOPE_RESET;
         offset_ff    <= skc_pkg::CAL_OFFSET_RESET;
         last_ff      <= '0;
         est_ff       <= skc_pkg::INIT_EST_ERROR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         meas_ff      <= meas_in;
         init_ff      <= init_in;
         noise_q_ff   <= noise_q_in;
         slope_ff     <= slope_in;
         offset_ff    <= offset_in;
         last_ff      <= last_in;
         est_ff       <= est_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      diff_ff     <= diff_in;
      den_ff      <= den_in;
      gain_ff     <= gain_in;
      change_ff   <= change_in;
      keep_ff     <= keep_in;
      filt_ff     <= filt_in;
      rsp_filt_ff <= rsp_filt_in;
      rsp_cal_ff  <= rsp_cal_in;
   end

   assign req.ready      = (state_ff == skc_pkg::S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.filtered   = rsp_filt_ff;
   assign rsp.calibrated = rsp_cal_ff;

endmodule
